[rtl/i2cm_pkg.sv]
// Shared types and constants for the I2C master register model.
package i2cm_pkg;

    localparam logic [11:0] OFS_CLKLO = 12'h000;
    localparam logic [11:0] OFS_CLKHI = 12'h004;
    localparam logic [11:0] OFS_CTRL  = 12'h008;
    localparam logic [11:0] OFS_TXRX  = 12'h00C;
    localparam logic [11:0] OFS_CMDST = 12'h010;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam int CTRL_EN_BIT  = 7;
    localparam int CTRL_IEN_BIT = 6;
    localparam int CTRL_EN_IDX  = 1;
    localparam int CTRL_IEN_IDX = 0;

    localparam int CMD_STA_BIT  = 7;
    localparam int CMD_STO_BIT  = 6;
    localparam int CMD_RD_BIT   = 5;
    localparam int CMD_WR_BIT   = 4;
    localparam int CMD_IACK_BIT = 0;

    localparam int ST_ACK_BIT = 7;
    localparam int ST_BSY_BIT = 6;
    localparam int ST_IF_BIT  = 0;

    typedef struct packed {
        logic       func;
        logic [11:0] reg_offset;
        logic [7:0] wdata;
        logic       dev_present;
        logic       wr_accept;
        logic       rd_accept;
        logic [7:0] dev_rdata;
    } in_item_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       irq_pulse;
        logic [6:0] dev_addr;
        logic       req_start;
        logic       dir_write;
        logic       req_write;
        logic [7:0] tx_data;
        logic       req_read;
        logic       req_stop;
    } out_item_t;

    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctl_t;

endpackage

[rtl/i2cm_in_stage.sv]
// Input register stage: captures one bus access and holds it until it advances.
module i2cm_in_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  i2cm_pkg::in_item_t in_item,
    input  logic               advance,
    output i2cm_pkg::in_item_t item,
    output logic               item_valid
);

    logic               valid_reg;
    logic               valid_next;
    logic               load;
    i2cm_pkg::in_item_t item_reg;

    assign in_stall   = valid_reg & ~advance;
    assign load       = in_valid & ~in_stall;
    assign valid_next = load | (valid_reg & ~advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

[rtl/i2cm_regfile.sv]
// Register file and command decode: one access per cycle, state updated on advance.
module i2cm_regfile
(
    input  logic                clk,
    input  logic                rst_n,
    input  i2cm_pkg::stage_ctl_t ctl,
    input  i2cm_pkg::in_item_t  item,
    output i2cm_pkg::out_item_t result
);

    logic [15:0] prescale_reg;
    logic [15:0] prescale_next;
    logic [1:0]  ctrl_reg;
    logic [1:0]  ctrl_next;
    logic [7:0]  status_reg;
    logic [7:0]  status_next;
    logic [7:0]  tx_hold_reg;
    logic [7:0]  tx_hold_next;
    logic [7:0]  rx_hold_reg;
    logic [7:0]  rx_hold_next;
    logic [6:0]  slave_sel_reg;
    logic [6:0]  slave_sel_next;
    logic        sel_none_reg;
    logic        sel_none_next;
    logic        fire;
    i2cm_pkg::out_item_t res;

    assign fire = ctl.valid & ctl.advance;

    always_comb
    begin
        prescale_next  = prescale_reg;
        ctrl_next      = ctrl_reg;
        status_next    = status_reg;
        tx_hold_next   = tx_hold_reg;
        rx_hold_next   = rx_hold_reg;
        slave_sel_next = slave_sel_reg;
        sel_none_next  = sel_none_reg;
        res            = '0;

        if (item.func == i2cm_pkg::FUNC_READ)
        begin
            unique case (item.reg_offset)
                i2cm_pkg::OFS_CLKLO: res.rdata = prescale_reg[7:0];
                i2cm_pkg::OFS_CLKHI: res.rdata = prescale_reg[15:8];
                i2cm_pkg::OFS_CTRL:  res.rdata = {ctrl_reg, 6'b0};
                i2cm_pkg::OFS_TXRX:  res.rdata = rx_hold_reg;
                i2cm_pkg::OFS_CMDST: res.rdata = status_reg;
                default:             res.rdata = 8'h00;
            endcase
        end
        else
        begin
            unique case (item.reg_offset)
                i2cm_pkg::OFS_CLKLO: prescale_next[7:0]  = item.wdata;
                i2cm_pkg::OFS_CLKHI: prescale_next[15:8] = item.wdata;
                i2cm_pkg::OFS_CTRL:
                begin
                    ctrl_next = {item.wdata[i2cm_pkg::CTRL_EN_BIT],
                                 item.wdata[i2cm_pkg::CTRL_IEN_BIT]};
                end
                i2cm_pkg::OFS_TXRX:  tx_hold_next = item.wdata;
                i2cm_pkg::OFS_CMDST:
                begin
                    status_next[i2cm_pkg::ST_ACK_BIT] = 1'b1;
                    if (item.wdata[i2cm_pkg::CMD_IACK_BIT])
                    begin
                        status_next[i2cm_pkg::ST_IF_BIT] = 1'b0;
                    end
                    if (item.wdata[i2cm_pkg::CMD_STA_BIT])
                    begin
                        sel_none_next                     = 1'b1;
                        status_next[i2cm_pkg::ST_BSY_BIT] = 1'b1;
                    end
                    if (item.wdata[i2cm_pkg::CMD_WR_BIT])
                    begin
                        if (sel_none_next)
                        begin
                            slave_sel_next = tx_hold_reg[7:1];
                            sel_none_next  = 1'b0;
                            if (item.dev_present)
                            begin
                                res.req_start = 1'b1;
                                res.dir_write = ~tx_hold_reg[0];
                                if (item.wr_accept)
                                begin
                                    status_next[i2cm_pkg::ST_ACK_BIT] = 1'b0;
                                end
                            end
                        end
                        else if (item.dev_present)
                        begin
                            res.req_write = 1'b1;
                            res.tx_data   = tx_hold_reg;
                            if (item.wr_accept)
                            begin
                                status_next[i2cm_pkg::ST_ACK_BIT] = 1'b0;
                            end
                        end
                        status_next[i2cm_pkg::ST_IF_BIT] = 1'b1;
                        res.irq_pulse = res.irq_pulse | ctrl_reg[i2cm_pkg::CTRL_IEN_IDX];
                    end
                    if (item.wdata[i2cm_pkg::CMD_RD_BIT])
                    begin
                        if (!sel_none_next && item.dev_present)
                        begin
                            res.req_read = 1'b1;
                            rx_hold_next = item.dev_rdata;
                            if (item.rd_accept)
                            begin
                                status_next[i2cm_pkg::ST_ACK_BIT] = 1'b0;
                            end
                        end
                        status_next[i2cm_pkg::ST_IF_BIT] = 1'b1;
                        res.irq_pulse = res.irq_pulse | ctrl_reg[i2cm_pkg::CTRL_IEN_IDX];
                    end
                    if (item.wdata[i2cm_pkg::CMD_STO_BIT])
                    begin
                        if (!sel_none_next && item.dev_present)
                        begin
                            res.req_stop = 1'b1;
                        end
                        sel_none_next                     = 1'b1;
                        status_next[i2cm_pkg::ST_BSY_BIT] = 1'b0;
                        status_next[i2cm_pkg::ST_IF_BIT]  = 1'b1;
                        res.irq_pulse = res.irq_pulse | ctrl_reg[i2cm_pkg::CTRL_IEN_IDX];
                    end
                    if (res.req_start | res.req_write | res.req_read | res.req_stop)
                    begin
                        res.dev_addr = slave_sel_next;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg  <= '0;
            ctrl_reg      <= '0;
            status_reg    <= '0;
            tx_hold_reg   <= '0;
            rx_hold_reg   <= '0;
            slave_sel_reg <= '0;
            sel_none_reg  <= 1'b0;
        end
        else if (fire)
        begin
            prescale_reg  <= prescale_next;
            ctrl_reg      <= ctrl_next;
            status_reg    <= status_next;
            tx_hold_reg   <= tx_hold_next;
            rx_hold_reg   <= rx_hold_next;
            slave_sel_reg <= slave_sel_next;
            sel_none_reg  <= sel_none_next;
        end
    end

    assign result = res;

    a_start_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> !(res.req_start && res.req_write))
        else $error("start and data write issued together");

    a_dir_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.dir_write |-> res.req_start)
        else $error("direction set without start request");

    a_irq_needs_ien: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.irq_pulse |-> ctrl_reg[i2cm_pkg::CTRL_IEN_IDX])
        else $error("interrupt pulse with interrupts disabled");

    a_status_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        status_reg[5:1] == 5'b0)
        else $error("unused status bits set");

    a_irq_sets_if: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.irq_pulse |=> status_reg[i2cm_pkg::ST_IF_BIT])
        else $error("interrupt raised without IF");

endmodule

[rtl/i2cm_out_stage.sv]
// Result register stage: holds one result until the receiver takes it.
module i2cm_out_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    input  i2cm_pkg::out_item_t src_item,
    output logic                advance,
    output logic                out_valid,
    input  logic                out_stall,
    output i2cm_pkg::out_item_t out_item
);

    logic                valid_reg;
    logic                valid_next;
    i2cm_pkg::out_item_t item_reg;

    assign advance    = src_valid & (~valid_reg | ~out_stall);
    assign valid_next = advance | (valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg <= src_item;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

[rtl/i2c_master_register_model.sv]
// Top level of the I2C master register model.
//
// Each input transfer is one register access (read or write at a byte offset);
// each produces exactly one output transfer with read data and bus requests.
// Both channels use valid/stall: a transfer completes on a rising edge with
// valid high and stall low.
// An accepted access passes the input register and then the result register
// before it is presented on out_valid.
// Throughput: one access per cycle while out_stall is low; the register file and
// command decode sit between the input register and the result register.
// Register state changes when an access moves into the result register, so
// accesses take effect strictly in order.
// Reset (rst_n low, asynchronous) clears all register-file state, empties both stages,
// and leaves slave 0 selected.
// When out_stall is held, the result register holds, the input register fills,
// and in_stall rises; nothing is dropped.
module i2c_master_register_model
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [11:0] reg_offset,
    input  logic [7:0]  wdata,
    input  logic        dev_present,
    input  logic        wr_accept,
    input  logic        rd_accept,
    input  logic [7:0]  dev_rdata,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  rdata,
    output logic        irq_pulse,
    output logic [6:0]  dev_addr,
    output logic        req_start,
    output logic        dir_write,
    output logic        req_write,
    output logic [7:0]  tx_data,
    output logic        req_read,
    output logic        req_stop
);

    i2cm_pkg::in_item_t   in_item;
    i2cm_pkg::in_item_t   s1_item;
    logic                 s1_valid;
    logic                 advance;
    i2cm_pkg::stage_ctl_t ctl;
    i2cm_pkg::out_item_t  result;
    i2cm_pkg::out_item_t  out_item;

    assign in_item.func        = func;
    assign in_item.reg_offset  = reg_offset;
    assign in_item.wdata       = wdata;
    assign in_item.dev_present = dev_present;
    assign in_item.wr_accept   = wr_accept;
    assign in_item.rd_accept   = rd_accept;
    assign in_item.dev_rdata   = dev_rdata;

    i2cm_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .advance    (advance),
        .item       (s1_item),
        .item_valid (s1_valid)
    );

    assign ctl.valid   = s1_valid;
    assign ctl.advance = advance;

    i2cm_regfile u_regfile
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .item   (s1_item),
        .result (result)
    );

    i2cm_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (s1_valid),
        .src_item  (result),
        .advance   (advance),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    assign rdata     = out_item.rdata;
    assign irq_pulse = out_item.irq_pulse;
    assign dev_addr  = out_item.dev_addr;
    assign req_start = out_item.req_start;
    assign dir_write = out_item.dir_write;
    assign req_write = out_item.req_write;
    assign tx_data   = out_item.tx_data;
    assign req_read  = out_item.req_read;
    assign req_stop  = out_item.req_stop;

endmodule
